// ===== hw/rtl/wbm_pkg.sv =====
// Shared types, widths and constants of the windowed bit-rate meter.
package wbm_pkg;

  localparam int PKT_W    = 24;
  localparam int DUR_W    = 32;
  localparam int WIN_W    = 32;
  localparam int NUM_W    = 16;
  localparam int DEN_W    = 32;
  localparam int BYTES_W  = 34;
  localparam int TICKS_W  = 48;
  localparam int RATE_W   = 40;
  localparam int SUM_W    = 56;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Divisor is tick_numerator * ticks, dividend is bytes * 8 * tick_denominator.
  localparam int DIVISOR_W  = NUM_W + TICKS_W;
  localparam int BYTE_SHIFT = 3;
  localparam int PROD_W     = BYTES_W + DEN_W;
  localparam int DVD_W      = PROD_W + BYTE_SHIFT;
  localparam int SPLIT_W    = BYTES_W / 2;
  localparam int PART_W     = SPLIT_W + DEN_W;
  localparam int REM_W      = DIVISOR_W + 1;
  localparam int DIV_STEPS  = DVD_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_NUMERATOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_DENOMINATOR = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_BYTES_RST     = 32'd2097152;
  localparam logic [NUM_W-1:0] TICK_NUMERATOR_RST   = 16'd1;
  localparam logic [DEN_W-1:0] TICK_DENOMINATOR_RST = 32'd90000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_MEASURE,
    EMIT_ERROR
  } emit_kind_t;

  typedef struct packed {
    logic       accum;
    logic       eval;
    logic       mul_lo;
    logic       mul_hi;
    logic       div_step;
    logic       emit;
    emit_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic over_window;
    logic div_zero;
    logic div_last;
  } status_t;

endpackage

// ===== hw/rtl/wbm_in_if.sv =====
// Packet channel: one word per packet.
interface wbm_in_if;
  logic                      valid;
  logic                      ready;
  logic [wbm_pkg::PKT_W-1:0] packet_bytes;
  logic [wbm_pkg::PKT_W-1:0] side_bytes;
  logic [wbm_pkg::DUR_W-1:0] duration_ticks;

  modport source (output valid, output packet_bytes, output side_bytes,
                  output duration_ticks, input ready);
  modport sink (input valid, input packet_bytes, input side_bytes,
                input duration_ticks, output ready);
endinterface

// ===== hw/rtl/wbm_out_if.sv =====
// Result channel: one word per packet.
interface wbm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        window_closed;
  logic [wbm_pkg::RATE_W-1:0]  rate_bps;
  logic [wbm_pkg::RATE_W-1:0]  min_rate_bps;
  logic [wbm_pkg::RATE_W-1:0]  max_rate_bps;
  logic [wbm_pkg::SUM_W-1:0]   rate_sum_bps;
  logic [wbm_pkg::COUNT_W-1:0] window_count;
  logic                        zero_duration_error;

  modport source (output valid, output window_closed, output rate_bps,
                  output min_rate_bps, output max_rate_bps, output rate_sum_bps,
                  output window_count, output zero_duration_error, input ready);
  modport sink (input valid, input window_closed, input rate_bps,
                input min_rate_bps, input max_rate_bps, input rate_sum_bps,
                input window_count, input zero_duration_error, output ready);
endinterface

// ===== hw/rtl/wbm_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface wbm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wbm_pkg::CFG_IDX_W-1:0]  index;
  logic [wbm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/wbm_ctrl.sv =====
// Sequencer of the meter: accumulate, compare, multiply, divide, emit.
module wbm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wbm_pkg::status_t  status,
  output wbm_pkg::cmd_t     cmd
);

  wbm_pkg::state_t     state_r, state_nxt;
  wbm_pkg::emit_kind_t kind_r, kind_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbm_pkg::ST_IDLE;
      kind_r      <= wbm_pkg::EMIT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.kind  = kind_r;
    case (state_r)
      wbm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accum = 1'b1;
          state_nxt = wbm_pkg::ST_EVAL;
        end
      end
      wbm_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.over_window) begin
          state_nxt = wbm_pkg::ST_MUL_LO;
        end else begin
          kind_nxt  = wbm_pkg::EMIT_NONE;
          state_nxt = wbm_pkg::ST_EMIT;
        end
      end
      wbm_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        if (status.div_zero) begin
          kind_nxt  = wbm_pkg::EMIT_ERROR;
          state_nxt = wbm_pkg::ST_EMIT;
        end else begin
          state_nxt = wbm_pkg::ST_MUL_HI;
        end
      end
      wbm_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = wbm_pkg::ST_DIV;
      end
      wbm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          kind_nxt  = wbm_pkg::EMIT_MEASURE;
          state_nxt = wbm_pkg::ST_EMIT;
        end
      end
      wbm_pkg::ST_EMIT: begin
        // The result word waits here until the output register is free.
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = wbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wbm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result word emitted over a word not yet taken");

  a_one_packet_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("packet accepted while the previous one is still at work");

  a_div_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wbm_pkg::ST_DIV && !status.div_last) |=> state_r == wbm_pkg::ST_DIV)
    else $error("divider left before its last step");

  a_zero_divisor_error: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wbm_pkg::ST_MUL_LO && status.div_zero) |=>
      (state_r == wbm_pkg::ST_EMIT && kind_r == wbm_pkg::EMIT_ERROR))
    else $error("zero divisor did not lead to an error word");

endmodule

// ===== hw/rtl/wbm_datapath.sv =====
// Window totals, multipliers, radix-2 divider, statistics and result register.
module wbm_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wbm_pkg::cmd_t                    cmd,
  output wbm_pkg::status_t                 status,
  input  logic [wbm_pkg::PKT_W-1:0]        packet_bytes,
  input  logic [wbm_pkg::PKT_W-1:0]        side_bytes,
  input  logic [wbm_pkg::DUR_W-1:0]        duration_ticks,
  input  logic                             cfg_we,
  input  logic [wbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             window_closed,
  output logic [wbm_pkg::RATE_W-1:0]       rate_bps,
  output logic [wbm_pkg::RATE_W-1:0]       min_rate_bps,
  output logic [wbm_pkg::RATE_W-1:0]       max_rate_bps,
  output logic [wbm_pkg::SUM_W-1:0]        rate_sum_bps,
  output logic [wbm_pkg::COUNT_W-1:0]      window_count,
  output logic                             zero_duration_error
);

  // Configuration.
  logic [wbm_pkg::WIN_W-1:0] win_r;
  logic [wbm_pkg::NUM_W-1:0] num_r;
  logic [wbm_pkg::DEN_W-1:0] den_r;

  // Window totals and statistics.
  logic [wbm_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [wbm_pkg::TICKS_W-1:0] ticks_r, ticks_nxt;
  logic [wbm_pkg::TICKS_W:0]   ticks_sum;
  logic                        have_r;
  logic [wbm_pkg::RATE_W-1:0]  min_r, max_r, min_nxt, max_nxt;
  logic [wbm_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [wbm_pkg::SUM_W:0]     sum_wide;
  logic [wbm_pkg::COUNT_W-1:0] count_r, count_nxt;

  // Arithmetic.
  logic [wbm_pkg::DIVISOR_W-1:0] divisor_r, divisor_nxt;
  logic [wbm_pkg::PART_W-1:0]    plo_r, plo_nxt, phi;
  logic [wbm_pkg::PROD_W-1:0]    prod;
  logic [wbm_pkg::DVD_W-1:0]     dvd_r;
  logic [wbm_pkg::REM_W-1:0]     rem_r, rem_shift, rem_diff;
  logic                          q_bit;
  logic [wbm_pkg::CNT_W-1:0]     cnt_r;
  logic [wbm_pkg::RATE_W-1:0]    rate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= wbm_pkg::WINDOW_BYTES_RST;
      num_r <= wbm_pkg::TICK_NUMERATOR_RST;
      den_r <= wbm_pkg::TICK_DENOMINATOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wbm_pkg::CFG_WINDOW_BYTES:     win_r <= cfg_data;
        wbm_pkg::CFG_TICK_NUMERATOR:   num_r <= cfg_data[wbm_pkg::NUM_W-1:0];
        wbm_pkg::CFG_TICK_DENOMINATOR: den_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bytes_nxt = bytes_r + {{(wbm_pkg::BYTES_W-wbm_pkg::PKT_W){1'b0}}, packet_bytes}
                             + {{(wbm_pkg::BYTES_W-wbm_pkg::PKT_W){1'b0}}, side_bytes};
  assign ticks_sum = {1'b0, ticks_r}
                   + {{(wbm_pkg::TICKS_W+1-wbm_pkg::DUR_W){1'b0}}, duration_ticks};
  assign ticks_nxt = ticks_sum[wbm_pkg::TICKS_W] ? '1 : ticks_sum[wbm_pkg::TICKS_W-1:0];

  assign status.over_window = bytes_r > {{(wbm_pkg::BYTES_W-wbm_pkg::WIN_W){1'b0}}, win_r};
  assign status.div_zero    = divisor_r == '0;
  assign status.div_last    = cnt_r == wbm_pkg::CNT_W'(wbm_pkg::DIV_STEPS - 1);

  // The dividend product is built from two 17 x 32 partial products.
  assign divisor_nxt = num_r * ticks_r;
  assign plo_nxt     = bytes_r[wbm_pkg::SPLIT_W-1:0] * den_r;
  assign phi         = bytes_r[wbm_pkg::BYTES_W-1:wbm_pkg::SPLIT_W] * den_r;
  assign prod = {{(wbm_pkg::PROD_W-wbm_pkg::PART_W){1'b0}}, plo_r}
              + {phi, {wbm_pkg::SPLIT_W{1'b0}}};

  // Restoring division; quotient bits shift into the dividend register.
  assign rem_shift = {rem_r[wbm_pkg::REM_W-2:0], dvd_r[wbm_pkg::DVD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor_r};
  assign q_bit     = rem_shift >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      divisor_r <= divisor_nxt;
    end
    if (cmd.mul_lo) begin
      plo_r <= plo_nxt;
    end
    if (cmd.mul_hi) begin
      dvd_r <= {prod, {wbm_pkg::BYTE_SHIFT{1'b0}}};
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[wbm_pkg::DVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff : rem_shift;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rate = (|dvd_r[wbm_pkg::DVD_W-1:wbm_pkg::RATE_W]) ? '1 : dvd_r[wbm_pkg::RATE_W-1:0];

  always_comb begin
    if (!have_r) begin
      min_nxt = rate;
      max_nxt = rate;
    end else begin
      min_nxt = (rate < min_r) ? rate : min_r;
      max_nxt = (rate > max_r) ? rate : max_r;
    end
    sum_wide  = {1'b0, sum_r} + {{(wbm_pkg::SUM_W+1-wbm_pkg::RATE_W){1'b0}}, rate};
    sum_nxt   = sum_wide[wbm_pkg::SUM_W] ? '1 : sum_wide[wbm_pkg::SUM_W-1:0];
    count_nxt = (count_r == '1) ? count_r : count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
      ticks_r <= '0;
      have_r  <= 1'b0;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
    end else if (cmd.accum) begin
      bytes_r <= bytes_nxt;
      ticks_r <= ticks_nxt;
    end else if (cmd.emit) begin
      if (cmd.kind != wbm_pkg::EMIT_NONE) begin
        bytes_r <= '0;
        ticks_r <= '0;
      end
      if (cmd.kind == wbm_pkg::EMIT_MEASURE) begin
        have_r  <= 1'b1;
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.kind == wbm_pkg::EMIT_MEASURE) begin
        window_closed <= 1'b1;
        rate_bps      <= rate;
        min_rate_bps  <= min_nxt;
        max_rate_bps  <= max_nxt;
        rate_sum_bps  <= sum_nxt;
        window_count  <= count_nxt;
      end else begin
        window_closed <= 1'b0;
        rate_bps      <= '0;
        min_rate_bps  <= min_r;
        max_rate_bps  <= max_r;
        rate_sum_bps  <= sum_r;
        window_count  <= count_r;
      end
      zero_duration_error <= cmd.kind == wbm_pkg::EMIT_ERROR;
    end
  end

endmodule

// ===== hw/rtl/windowed_bitrate_meter.sv =====
// Top level of the windowed bit-rate meter: handshake glue around sequencer and datapath.
//
// Each packet word adds its payload and side-data bytes and its duration to the window
// totals and yields exactly one result word. A packet that leaves the byte total at or
// below window_bytes passes accumulate, compare and emit; a window closing on a zero
// divisor adds the low partial-product step before emit; a window closing with a measure
// runs accumulate, compare and divisor forming, the two partial products of the dividend,
// the radix-2 divider, and the update of the statistics and the output register in turn.
// One packet is at work at a time; the output register holds a finished word while the
// next packet is taken. The configuration port is always ready; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module windowed_bitrate_meter (
  input  logic      clk,
  input  logic      rst_n,
  wbm_in_if.sink    in_port,
  wbm_out_if.source out_port,
  wbm_cfg_if.sink   cfg_port
);

  wbm_pkg::cmd_t    cmd;
  wbm_pkg::status_t status;
  logic             in_ready;
  logic             out_valid;

  assign in_port.ready  = in_ready;
  assign out_port.valid = out_valid;
  assign cfg_port.ready = 1'b1;

  wbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_port.ready),
    .status    (status),
    .cmd       (cmd)
  );

  wbm_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .packet_bytes        (in_port.packet_bytes),
    .side_bytes          (in_port.side_bytes),
    .duration_ticks      (in_port.duration_ticks),
    .cfg_we              (cfg_port.valid),
    .cfg_index           (cfg_port.index),
    .cfg_data            (cfg_port.data),
    .window_closed       (out_port.window_closed),
    .rate_bps            (out_port.rate_bps),
    .min_rate_bps        (out_port.min_rate_bps),
    .max_rate_bps        (out_port.max_rate_bps),
    .rate_sum_bps        (out_port.rate_sum_bps),
    .window_count        (out_port.window_count),
    .zero_duration_error (out_port.zero_duration_error)
  );

endmodule

// ===== tb/windowed_bitrate_meter_tb.sv =====
// Self-checking testbench of the windowed bit-rate meter with its own bit-exact predictor.
`timescale 1ns / 100ps

module windowed_bitrate_meter_tb;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int DRAIN_CYCLES  = 100;
  localparam int HOLD_CYCLES   = 600;
  localparam longint unsigned CYCLE_LIMIT = 5000000;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int SAT_PACKETS   = 40;
  localparam logic [wbm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [wbm_pkg::RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic [wbm_pkg::PKT_W-1:0] payload;
    logic [wbm_pkg::PKT_W-1:0] side;
    logic [wbm_pkg::DUR_W-1:0] ticks;
  } packet_t;

  typedef struct packed {
    logic                        closed;
    logic [wbm_pkg::RATE_W-1:0]  rate;
    logic [wbm_pkg::RATE_W-1:0]  min_rate;
    logic [wbm_pkg::RATE_W-1:0]  max_rate;
    logic [wbm_pkg::SUM_W-1:0]   sum;
    logic [wbm_pkg::COUNT_W-1:0] count;
    logic                        zero_err;
  } meter_word_t;

  logic clk = 1'b0;
  logic rst_n;

  wbm_in_if  in_bus ();
  wbm_out_if out_bus ();
  wbm_cfg_if cfg_bus ();

  windowed_bitrate_meter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_bus),
    .out_port (out_bus),
    .cfg_port (cfg_bus)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor copy of the registers and the window state.
  logic [wbm_pkg::WIN_W-1:0]   cfg_window = wbm_pkg::WINDOW_BYTES_RST;
  logic [wbm_pkg::NUM_W-1:0]   cfg_num    = wbm_pkg::TICK_NUMERATOR_RST;
  logic [wbm_pkg::DEN_W-1:0]   cfg_den    = wbm_pkg::TICK_DENOMINATOR_RST;
  logic [wbm_pkg::BYTES_W-1:0] win_bytes  = '0;
  logic [wbm_pkg::TICKS_W-1:0] win_ticks  = '0;
  logic                        seen_measure = 1'b0;
  logic [wbm_pkg::RATE_W-1:0]  low_rate   = '0;
  logic [wbm_pkg::RATE_W-1:0]  high_rate  = '0;
  logic [wbm_pkg::SUM_W-1:0]   sum_rate   = '0;
  logic [wbm_pkg::COUNT_W-1:0] n_measures = '0;

  meter_word_t pending_results[$];
  meter_word_t want_word;
  int          mismatch_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_token = 0;
  longint unsigned cycle_count = 0;

  // Adds one packet to the window and returns the word the meter must report for it.
  function automatic meter_word_t meter_window_step(packet_t p);
    logic [wbm_pkg::TICKS_W:0]  tick_sum;
    logic [63:0]                divisor;
    logic [127:0]               dividend;
    logic [127:0]               quotient;
    logic [wbm_pkg::SUM_W:0]    new_sum;
    logic [wbm_pkg::RATE_W-1:0] rate;
    meter_word_t                w;
    w = '0;
    win_bytes = win_bytes + p.payload + p.side;
    tick_sum = win_ticks + p.ticks;
    win_ticks = tick_sum[wbm_pkg::TICKS_W] ? '1 : tick_sum[wbm_pkg::TICKS_W-1:0];
    if (win_bytes > wbm_pkg::BYTES_W'(cfg_window)) begin
      divisor = 64'(cfg_num) * 64'(win_ticks);
      if (divisor == 64'd0) begin
        w.zero_err = 1'b1;
      end else begin
        dividend = (128'(win_bytes) << wbm_pkg::BYTE_SHIFT) * 128'(cfg_den);
        quotient = dividend / 128'(divisor);
        rate = (quotient > 128'(RATE_MAX)) ? RATE_MAX : quotient[wbm_pkg::RATE_W-1:0];
        w.closed = 1'b1;
        w.rate = rate;
        if (!seen_measure) begin
          low_rate = rate;
          high_rate = rate;
          seen_measure = 1'b1;
        end else begin
          if (rate < low_rate) low_rate = rate;
          if (rate > high_rate) high_rate = rate;
        end
        new_sum = sum_rate + rate;
        sum_rate = new_sum[wbm_pkg::SUM_W] ? '1 : new_sum[wbm_pkg::SUM_W-1:0];
        if (n_measures != '1) n_measures = n_measures + 1'b1;
      end
      win_bytes = '0;
      win_ticks = '0;
    end
    w.min_rate = low_rate;
    w.max_rate = high_rate;
    w.sum = sum_rate;
    w.count = n_measures;
    return w;
  endfunction

  function automatic packet_t random_packet();
    packet_t     p;
    int unsigned span;
    span = cfg_window / 3 + 1;
    if (span > 32'h00FF_FFFF) span = 32'h00FF_FFFF;
    case ($urandom_range(9))
      0: p.payload = wbm_pkg::PKT_W'($urandom);
      1: p.payload = '0;
      default: p.payload = wbm_pkg::PKT_W'($urandom_range(span, 0));
    endcase
    case ($urandom_range(9))
      0: p.side = wbm_pkg::PKT_W'($urandom);
      1, 2, 3: p.side = wbm_pkg::PKT_W'($urandom_range(span / 4 + 1, 0));
      default: p.side = '0;
    endcase
    case ($urandom_range(9))
      0: p.ticks = '0;
      1: p.ticks = $urandom;
      2: p.ticks = '1;
      default: p.ticks = $urandom_range(100000, 1);
    endcase
    return p;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every accepted word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word: expected none, got closed=%0d rate=%0d",
               out_bus.window_closed, out_bus.rate_bps);
        mismatch_count++;
      end else begin
        want_word = pending_results.pop_front();
        compare_field("window_closed", want_word.closed, out_bus.window_closed);
        compare_field("rate_bps", want_word.rate, out_bus.rate_bps);
        compare_field("min_rate_bps", want_word.min_rate, out_bus.min_rate_bps);
        compare_field("max_rate_bps", want_word.max_rate, out_bus.max_rate_bps);
        compare_field("rate_sum_bps", want_word.sum, out_bus.rate_sum_bps);
        compare_field("window_count", want_word.count, out_bus.window_count);
        compare_field("zero_duration_error", want_word.zero_err,
                      out_bus.zero_duration_error);
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off whenever a test asks for one.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[windowed_bitrate_meter] ERROR");
      $finish;
    end
  end

  // Offers one packet word; valid stays high after acceptance unless the next call idles.
  task automatic send_packet(input packet_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.packet_bytes <= p.payload;
    in_bus.side_bytes <= p.side;
    in_bus.duration_ticks <= p.ticks;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pending_results.push_back(meter_window_step(p));
  endtask

  task automatic send_fields(input logic [wbm_pkg::PKT_W-1:0] payload,
                             input logic [wbm_pkg::PKT_W-1:0] side,
                             input logic [wbm_pkg::DUR_W-1:0] ticks);
    send_packet('{payload: payload, side: side, ticks: ticks});
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [wbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wbm_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      wbm_pkg::CFG_WINDOW_BYTES:     cfg_window = data[wbm_pkg::WIN_W-1:0];
      wbm_pkg::CFG_TICK_NUMERATOR:   cfg_num = data[wbm_pkg::NUM_W-1:0];
      wbm_pkg::CFG_TICK_DENOMINATOR: cfg_den = data[wbm_pkg::DEN_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all three registers, then a word to the unused index that must be ignored.
  task automatic set_config(input logic [wbm_pkg::CFG_DATA_W-1:0] window,
                            input logic [wbm_pkg::CFG_DATA_W-1:0] num_word,
                            input logic [wbm_pkg::CFG_DATA_W-1:0] den);
    wait_idle();
    write_reg(wbm_pkg::CFG_WINDOW_BYTES, window);
    write_reg(wbm_pkg::CFG_TICK_NUMERATOR, num_word);
    write_reg(wbm_pkg::CFG_TICK_DENOMINATOR, den);
    write_reg(CFG_UNUSED, $urandom);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    idle_pct = 0;
    stall_pct = 0;
    send_fields(24'd1000, 24'd0, 32'd3000);
    send_fields('1, '1, 32'd0);
    // A window of bytes with no ticks behind it closes without a measure.
    send_fields('1, 24'd0, 32'd0);
    send_fields(24'd0, 24'd0, '1);
    send_fields(24'd0, 24'd0, 32'd0);
  endtask

  task automatic test_zero_divisor();
    // Bit 16 of the numerator word is masked off, so the numerator becomes zero.
    set_config(32'd1000, 32'h0001_0000, 32'd90000);
    send_fields(24'd2000, 24'd0, 32'd100);
    send_fields(24'd500, 24'd600, 32'd7);
    set_config(32'd1000, 32'd1, 32'd0);
    send_fields(24'd5000, 24'd0, 32'd10);
    send_fields(24'd0, 24'd1001, 32'd1);
  endtask

  task automatic test_zero_window();
    set_config(32'd0, 32'd1, 32'd90000);
    send_fields(24'd0, 24'd0, 32'd5);
    send_fields(24'd0, 24'd1, 32'd0);
    send_fields(24'd1, 24'd0, 32'd0);
    send_fields(24'd1, 24'd0, 32'd1);
  endtask

  task automatic test_rate_extremes();
    set_config(32'd0, 32'd1, 32'hFFFF_FFFF);
    send_fields('1, '1, 32'd1);
    send_fields('1, '1, '1);
    set_config(32'd0, 32'h0000_FFFF, 32'd1);
    send_fields(24'd1, 24'd0, '1);
    send_fields(24'h55_5555, 24'hAA_AAAA, 32'h5555_5555);
    send_fields(24'hAA_AAAA, 24'h55_5555, 32'hAAAA_AAAA);
  endtask

  // Maximum-duration packets build a tick total far beyond 32 bits, then full-size
  // packets fill bytes until the widest window closes.
  task automatic test_tick_saturation();
    set_config(32'hFFFF_FFFF, 32'd1, 32'd1);
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < SAT_PACKETS; i++) send_fields(24'd0, 24'd0, '1);
    for (int i = 0; i < 130; i++) send_fields('1, '1, '1);
  endtask

  // The receiver holds off while packets keep coming, so the block must stall its input.
  task automatic test_backpressure();
    set_config(32'd300, 32'd1, 32'd90000);
    idle_pct = 0;
    stall_pct = 0;
    hold_token <= hold_token + 1;
    for (int i = 0; i < 12; i++) send_fields(24'd200, 24'(i), 32'($urandom_range(5000, 1)));
  endtask

  task automatic run_random_phase(input int idle, input int stall, input int count);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_packet(random_packet());
  endtask

  task automatic test_random_traffic();
    set_config(wbm_pkg::WINDOW_BYTES_RST, wbm_pkg::TICK_NUMERATOR_RST,
               wbm_pkg::TICK_DENOMINATOR_RST);
    run_random_phase(0, 0, RANDOM_PER_PHASE);
    set_config($urandom_range(4000000, 1), $urandom_range(65535, 1), $urandom);
    run_random_phase(79, 0, RANDOM_PER_PHASE);
    set_config($urandom_range(5000, 1), 32'h0000_FFFF, 32'hFFFF_FFFF);
    run_random_phase(0, 79, RANDOM_PER_PHASE);
    set_config($urandom_range(200000, 1000), 32'd1, 32'd1);
    run_random_phase(18, 18, RANDOM_PER_PHASE);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.packet_bytes <= '0;
    in_bus.side_bytes <= '0;
    in_bus.duration_ticks <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= wbm_pkg::CFG_WINDOW_BYTES;
    cfg_bus.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_zero_divisor();
    test_zero_window();
    test_rate_extremes();
    test_tick_saturation();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[windowed_bitrate_meter] OK");
    end else begin
      $display("[windowed_bitrate_meter] ERROR");
    end
    $finish;
  end

endmodule
